@@ rtl/art_pkg.sv @@
// Shared types and constants of the pending-ack retransmit table.
package art_pkg;

    localparam int PENDING_SLOTS_DEF = 8;
    localparam int MSG_ID_W          = 16;
    localparam int NODE_W            = 8;
    localparam int TAG_W             = 16;
    localparam int TIME_W            = 32;
    localparam int RETRY_W           = 8;
    localparam int CMD_W             = 2;

    localparam logic [TIME_W-1:0] ACK_TIMEOUT_RST = TIME_W'(1000);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [TIME_W-1:0]   now_ms;
        logic [MSG_ID_W-1:0] msg_id;
        logic [NODE_W-1:0]   node_id;
        logic [TAG_W-1:0]    packet_tag;
        logic [RETRY_W-1:0]  max_retries;
    } item_t;

    typedef struct packed {
        logic [MSG_ID_W-1:0] msg_id;
        logic [NODE_W-1:0]   receiver;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   sent_time;
        logic [RETRY_W-1:0]  retries;
    } slot_t;

    typedef struct packed {
        logic                ok;
        logic [MSG_ID_W-1:0] retry_msg_id;
        logic [NODE_W-1:0]   retry_node_id;
        logic [TAG_W-1:0]    retry_tag;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic item_load;
        logic set_active;
        logic clr_active;
        logic clr_all;
        logic wr_add;
        logic wr_check;
        logic res_load;
        logic res_ok;
        logic res_slot;
        logic out_load;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t item_cmd;
        logic slot_active;
        logic id_match;
        logic timed_out;
        logic has_retries;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/art_req_if.sv @@
// Command channel interface: one beat is one table command.
interface art_req_if;
    logic                          valid;
    logic                          ready;
    logic [art_pkg::CMD_W-1:0]     cmd;
    logic [art_pkg::TIME_W-1:0]    now_ms;
    logic [art_pkg::MSG_ID_W-1:0]  msg_id;
    logic [art_pkg::NODE_W-1:0]    node_id;
    logic [art_pkg::TAG_W-1:0]     packet_tag;
    logic [art_pkg::RETRY_W-1:0]   max_retries;

    modport source (output valid, cmd, now_ms, msg_id, node_id, packet_tag, max_retries,
                    input ready);
    modport sink   (input valid, cmd, now_ms, msg_id, node_id, packet_tag, max_retries,
                    output ready);
endinterface

@@ rtl/art_rsp_if.sv @@
// Result channel interface: one beat per command.
interface art_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [art_pkg::MSG_ID_W-1:0]  retry_msg_id;
    logic [art_pkg::NODE_W-1:0]    retry_node_id;
    logic [art_pkg::TAG_W-1:0]     retry_tag;

    modport source (output valid, ok, retry_msg_id, retry_node_id, retry_tag, input ready);
    modport sink   (input valid, ok, retry_msg_id, retry_node_id, retry_tag, output ready);
endinterface

@@ rtl/art_cfg_if.sv @@
// Configuration write channel interface: carries the ack timeout.
interface art_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [art_pkg::TIME_W-1:0]    ack_timeout;

    modport source (output valid, ack_timeout, input ready);
    modport sink   (input valid, ack_timeout, output ready);
endinterface

@@ rtl/art_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/art_datapath.sv @@
// Datapath: slot RAM, active flags, timeout register, compares and result registers.
module art_datapath #(
    parameter int PENDING_SLOTS = art_pkg::PENDING_SLOTS_DEF,
    parameter int IDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  art_pkg::ctl_t              ctl,
    input  logic [IDX_W-1:0]           scan_idx,
    input  logic [IDX_W-1:0]           rd_addr,
    input  art_pkg::item_t             item,
    input  logic                       cfg_we,
    input  logic [art_pkg::TIME_W-1:0] cfg_data,
    input  logic                       out_ready,
    output art_pkg::sts_t              sts,
    output logic                       out_valid,
    output art_pkg::res_t              out_data
);
    import art_pkg::*;

    item_t                    item_reg;
    logic [TIME_W-1:0]        timeout_reg;
    logic [PENDING_SLOTS-1:0] active_reg, active_next;
    res_t                     res_reg, res_next;
    res_t                     out_reg;
    logic                     out_valid_reg, out_valid_next;
    slot_t                    rd_slot, wr_slot;
    logic [$bits(slot_t)-1:0] rd_bits;
    logic [TIME_W-1:0]        elapsed;

    art_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (PENDING_SLOTS),
        .ADDR_W(IDX_W)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ctl.wr_add | ctl.wr_check),
        .waddr(scan_idx),
        .wdata(wr_slot),
        .raddr(rd_addr),
        .rdata(rd_bits)
    );

    assign rd_slot = slot_t'(rd_bits);
    assign elapsed = item_reg.now_ms - rd_slot.sent_time;  // wraps mod 2^32

    always_comb
    begin
        if (ctl.wr_add)
        begin
            wr_slot.msg_id    = item_reg.msg_id;
            wr_slot.receiver  = item_reg.node_id;
            wr_slot.tag       = item_reg.packet_tag;
            wr_slot.sent_time = item_reg.now_ms;
            wr_slot.retries   = item_reg.max_retries;
        end
        else
        begin
            // check restamp: spend one retry
            wr_slot           = rd_slot;
            wr_slot.sent_time = item_reg.now_ms;
            wr_slot.retries   = rd_slot.retries - RETRY_W'(1);
        end
    end

    always_comb
    begin
        sts.item_cmd    = item_reg.cmd;
        sts.slot_active = active_reg[scan_idx];
        sts.id_match    = (rd_slot.msg_id == item_reg.msg_id) &&
                          (rd_slot.receiver == item_reg.node_id);
        sts.timed_out   = (elapsed >= timeout_reg);
        sts.has_retries = (rd_slot.retries != '0);
        sts.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        active_next = active_reg;
        if (ctl.clr_all)
        begin
            active_next = '0;
        end
        else if (ctl.set_active)
        begin
            active_next[scan_idx] = 1'b1;
        end
        else if (ctl.clr_active)
        begin
            active_next[scan_idx] = 1'b0;
        end

        res_next = res_reg;
        if (ctl.res_load)
        begin
            res_next    = '0;
            res_next.ok = ctl.res_ok;
            if (ctl.res_slot)
            begin
                res_next.retry_msg_id  = rd_slot.msg_id;
                res_next.retry_node_id = rd_slot.receiver;
                res_next.retry_tag     = rd_slot.tag;
            end
        end

        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            timeout_reg   <= ACK_TIMEOUT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (ctl.item_load)
        begin
            item_reg <= item;
        end
        if (ctl.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.wr_add && ctl.wr_check))
        else $error("add and check write in the same cycle");

    a_add_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_add |=> active_reg[$past(scan_idx)])
        else $error("added slot not marked active");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> out_valid_reg && (out_reg == $past(res_reg)))
        else $error("result beat not presented after load");
endmodule

@@ rtl/art_ctrl.sv @@
// Controller: command FSM and slot scan counter.
module art_ctrl #(
    parameter int PENDING_SLOTS = art_pkg::PENDING_SLOTS_DEF,
    parameter int IDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  art_pkg::sts_t    sts,
    output art_pkg::ctl_t    ctl,
    output logic [IDX_W-1:0] scan_idx,
    output logic [IDX_W-1:0] rd_addr
);
    import art_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PENDING_SLOTS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        logic last;
        logic step;

        last       = (idx_reg == LAST_IDX);
        step       = 1'b0;
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        rd_addr    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.item_load = 1'b1;
                    idx_next      = '0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // read one slot ahead; data for idx_reg is on the RAM output
                rd_addr = last ? idx_reg : (idx_reg + IDX_W'(1));
                case (sts.item_cmd)
                    CMD_ADD:
                    begin
                        if (!sts.slot_active)
                        begin
                            ctl.wr_add     = 1'b1;
                            ctl.set_active = 1'b1;
                            ctl.res_load   = 1'b1;
                            ctl.res_ok     = 1'b1;
                            state_next     = ST_DELIVER;
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end

                    CMD_ACK:
                    begin
                        if (sts.slot_active && sts.id_match)
                        begin
                            ctl.clr_active = 1'b1;
                            ctl.res_load   = 1'b1;
                            ctl.res_ok     = 1'b1;
                            state_next     = ST_DELIVER;
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end

                    CMD_CHECK:
                    begin
                        if (sts.slot_active && sts.timed_out && sts.has_retries)
                        begin
                            ctl.wr_check = 1'b1;
                            ctl.res_load = 1'b1;
                            ctl.res_ok   = 1'b1;
                            ctl.res_slot = 1'b1;
                            state_next   = ST_DELIVER;
                        end
                        else
                        begin
                            // expired with no budget left: drop it and go on
                            ctl.clr_active = sts.slot_active && sts.timed_out;
                            step           = 1'b1;
                        end
                    end

                    default:
                    begin
                        ctl.clr_all  = 1'b1;
                        ctl.res_load = 1'b1;
                        state_next   = ST_DELIVER;
                    end
                endcase

                if (step)
                begin
                    if (last)
                    begin
                        ctl.res_load = 1'b1;
                        state_next   = ST_DELIVER;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_DELIVER:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign scan_idx = idx_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("scan index beyond last slot");

    a_res_to_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_load |=> state_reg == ST_DELIVER)
        else $error("result decided but not delivered");

    a_deliver_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER) && sts.out_free |=> state_reg == ST_IDLE)
        else $error("free output slot but result not handed over");
endmodule

@@ rtl/ack_retransmit_table_top.sv @@
// Top level of the pending-ack retransmit table.
// Usage:
//   req : one beat per command (add, ack, check, clear) with time, ids, tag
//         and retry budget. Accepted when req.valid and req.ready are high.
//   rsp : exactly one beat per command: ok plus the packet to resend when a
//         check finds a timed-out slot with retries left (else fields are 0).
//   cfg : writes the ack timeout in ms; reset value 1000. Write only while
//         the table is idle.
// Timing: after the accept edge the controller scans one slot per cycle
//   through the slot RAM (one read port, registered read, next slot
//   prefetched). A command stops at its hit slot or after the last slot,
//   its result goes to the output register, and req.ready rises in the
//   same cycle as rsp.valid; clear needs no scan. A new command is only
//   accepted once the previous result is in the output register.
// Reset: all slots are freed and the timeout returns to 1000 at once; no
//   clearing pass. The slot RAM contents are only used for active slots.
// Stall: the finished result sits in the output register; the next command
//   is accepted and scanned meanwhile, and waits to hand over its own result
//   until rsp.ready drains the previous beat.
module ack_retransmit_table_top #(
    parameter int PENDING_SLOTS = art_pkg::PENDING_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    art_req_if.sink   req,
    art_rsp_if.source rsp,
    art_cfg_if.sink   cfg
);
    import art_pkg::*;

    localparam int IDX_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

    ctl_t             ctl;
    sts_t             sts;
    item_t            item;
    res_t             out_data;
    logic             out_valid;
    logic [IDX_W-1:0] scan_idx;
    logic [IDX_W-1:0] rd_addr;

    // command beat payload
    assign item.cmd         = cmd_t'(req.cmd);
    assign item.now_ms      = req.now_ms;
    assign item.msg_id      = req.msg_id;
    assign item.node_id     = req.node_id;
    assign item.packet_tag  = req.packet_tag;
    assign item.max_retries = req.max_retries;

    // timeout register always takes a write beat
    assign cfg.ready = 1'b1;

    art_ctrl #(
        .PENDING_SLOTS(PENDING_SLOTS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req.valid),
        .req_ready(req.ready),
        .sts      (sts),
        .ctl      (ctl),
        .scan_idx (scan_idx),
        .rd_addr  (rd_addr)
    );

    art_datapath #(
        .PENDING_SLOTS(PENDING_SLOTS),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .scan_idx (scan_idx),
        .rd_addr  (rd_addr),
        .item     (item),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.ack_timeout),
        .out_ready(rsp.ready),
        .sts      (sts),
        .out_valid(out_valid),
        .out_data (out_data)
    );

    // result beat
    assign rsp.valid         = out_valid;
    assign rsp.ok            = out_data.ok;
    assign rsp.retry_msg_id  = out_data.retry_msg_id;
    assign rsp.retry_node_id = out_data.retry_node_id;
    assign rsp.retry_tag     = out_data.retry_tag;
endmodule

@@ tb/tb_ack_retransmit_table_top.sv @@
// Testbench for the pending-ack retransmit table: directed corners plus random traffic.
`timescale 1ns / 100ps

module tb_ack_retransmit_table_top;
    import art_pkg::*;

    localparam int SLOTS = PENDING_SLOTS_DEF;

    logic clk;
    logic rst_n;

    art_req_if req ();
    art_rsp_if rsp ();
    art_cfg_if cfg ();

    ack_retransmit_table_top #(
        .PENDING_SLOTS(SLOTS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source),
        .cfg  (cfg.sink)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the table, updated as each command beat is accepted.
    logic                tbl_active  [SLOTS];
    logic [MSG_ID_W-1:0] tbl_msg     [SLOTS];
    logic [NODE_W-1:0]   tbl_node    [SLOTS];
    logic [TAG_W-1:0]    tbl_tag     [SLOTS];
    logic [TIME_W-1:0]   tbl_sent    [SLOTS];
    logic [RETRY_W-1:0]  tbl_retries [SLOTS];
    logic [TIME_W-1:0]   cur_timeout;

    // Results still owed by the block, oldest first.
    res_t expected_rsp[$];
    int   fail_count;

    // Sender burst shaping.
    int burst_left;

    // Running clock of the random traffic, wraps like the real ms counter.
    logic [TIME_W-1:0] traffic_now;

    // Apply one command to the shadow table and return the result it must give.
    function automatic res_t predict_table(input item_t it);
        res_t              r;
        logic [TIME_W-1:0] elapsed;
        bit                done;
        r    = '0;
        done = 1'b0;
        case (it.cmd)
            CMD_ADD:
            begin
                // lowest free slot; table full -> dropped, ok=0
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && !tbl_active[i])
                    begin
                        tbl_msg[i]     = it.msg_id;
                        tbl_node[i]    = it.node_id;
                        tbl_tag[i]     = it.packet_tag;
                        tbl_sent[i]    = it.now_ms;
                        tbl_retries[i] = it.max_retries;
                        tbl_active[i]  = 1'b1;
                        r.ok           = 1'b1;
                        done           = 1'b1;
                    end
                end
            end
            CMD_ACK:
            begin
                // only the lowest of duplicate entries is freed
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && tbl_active[i] && tbl_msg[i] == it.msg_id &&
                        tbl_node[i] == it.node_id)
                    begin
                        tbl_active[i] = 1'b0;
                        r.ok          = 1'b1;
                        done          = 1'b1;
                    end
                end
            end
            CMD_CHECK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && tbl_active[i])
                    begin
                        elapsed = it.now_ms - tbl_sent[i];
                        if (elapsed >= cur_timeout)
                        begin
                            if (tbl_retries[i] != '0)
                            begin
                                tbl_retries[i]  = tbl_retries[i] - 1'b1;
                                tbl_sent[i]     = it.now_ms;
                                r.ok            = 1'b1;
                                r.retry_msg_id  = tbl_msg[i];
                                r.retry_node_id = tbl_node[i];
                                r.retry_tag     = tbl_tag[i];
                                done            = 1'b1;
                            end
                            else
                            begin
                                // out of retries: dropped as the scan passes
                                tbl_active[i] = 1'b0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    tbl_active[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic item_t make_item(input cmd_t c, input logic [TIME_W-1:0] now,
                                        input logic [MSG_ID_W-1:0] mid,
                                        input logic [NODE_W-1:0] node,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [RETRY_W-1:0] rmax);
        item_t it;
        it.cmd         = c;
        it.now_ms      = now;
        it.msg_id      = mid;
        it.node_id     = node;
        it.packet_tag  = tag;
        it.max_retries = rmax;
        return it;
    endfunction

    // Random active slot of the shadow table, -1 when empty.
    function automatic int pick_active_slot();
        int idx[$];
        for (int i = 0; i < SLOTS; i++)
            if (tbl_active[i])
                idx.push_back(i);
        if (idx.size() == 0)
            return -1;
        return idx[$urandom_range(0, idx.size() - 1)];
    endfunction

    // Mostly well-formed traffic: adds from a small id pool, acks aimed at live
    // entries, checks on an advancing clock; the rest is raw noise.
    function automatic item_t next_traffic_item();
        item_t it;
        int    roll;
        int    s;
        int    step_max;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            traffic_now = $urandom();
        else
        begin
            step_max    = (cur_timeout > 3000) ? 1500 : int'(cur_timeout / 2) + 2;
            traffic_now = traffic_now + TIME_W'($urandom_range(0, step_max));
        end
        // fields a command ignores still carry random bits
        it = make_item(CMD_CHECK, traffic_now, MSG_ID_W'($urandom()), NODE_W'($urandom()),
                       TAG_W'($urandom()), RETRY_W'($urandom()));
        if (roll < 7)
        begin
            it.cmd    = cmd_t'($urandom_range(0, 3));
            it.now_ms = $urandom();
        end
        else if (roll < 42)
        begin
            it.cmd = CMD_ADD;
            if ($urandom_range(0, 1) == 0)
                it.msg_id = MSG_ID_W'($urandom_range(0, 5));
            if ($urandom_range(0, 3) != 0)
                it.node_id = NODE_W'($urandom_range(0, 3));
            if ($urandom_range(0, 4) != 0)
                it.max_retries = RETRY_W'($urandom_range(0, 3));
        end
        else if (roll < 67)
        begin
            it.cmd = CMD_ACK;
            s      = pick_active_slot();
            if (s >= 0 && $urandom_range(0, 4) != 0)
            begin
                it.msg_id  = tbl_msg[s];
                it.node_id = tbl_node[s];
            end
            else
            begin
                it.msg_id  = MSG_ID_W'($urandom_range(0, 5));
                it.node_id = NODE_W'($urandom_range(0, 3));
            end
        end
        else if (roll < 97)
            it.cmd = CMD_CHECK;
        else
            it.cmd = CMD_CLEAR;
        return it;
    endfunction

    // Present one command beat and hold it until accepted. Called at a rising
    // edge; within a burst it returns at the accepting edge with valid still high,
    // so the following beat goes out back to back; at a burst end it drops valid first.
    task automatic send_cmd(input item_t it);
        int gap;
        req.valid       <= 1'b1;
        req.cmd         <= it.cmd;
        req.now_ms      <= it.now_ms;
        req.msg_id      <= it.msg_id;
        req.node_id     <= it.node_id;
        req.packet_tag  <= it.packet_tag;
        req.max_retries <= it.max_retries;
        do
            @(posedge clk);
        while (!req.ready);
        expected_rsp.push_back(predict_table(it));
        // end of burst: random gap, then a new burst length
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Stop sending and wait for every owed result, then let the table go idle.
    task automatic drain_table;
        req.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 8) @(posedge clk);
    endtask

    // Timeout is only written with the table idle.
    task automatic set_ack_timeout(input logic [TIME_W-1:0] value);
        drain_table();
        cfg.valid       <= 1'b1;
        cfg.ack_timeout <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid   <= 1'b0;
        cur_timeout = value;
    endtask

    // ---------------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------------

    // Check and ack against an empty table, reset timeout.
    task automatic test_empty_table;
        send_cmd(make_item(CMD_CHECK, 32'h0000_0000, 16'h0000, 8'h00, 16'h0000, 8'h00));
        send_cmd(make_item(CMD_ACK, 32'hFFFF_FFFF, 16'h0000, 8'h00, 16'hFFFF, 8'hFF));
    endtask

    // Eight adds fill the table, with field extremes and a duplicate pair;
    // the ninth is dropped.
    task automatic test_fill_and_full;
        send_cmd(make_item(CMD_ADD, 32'hFFFF_FF00, 16'h0000, 8'h00, 16'h0000, 8'h00));
        send_cmd(make_item(CMD_ADD, 32'hFFFF_FF00, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF));
        send_cmd(make_item(CMD_ADD, 32'd100, 16'h1234, 8'h05, 16'h0001, 8'h01));
        send_cmd(make_item(CMD_ADD, 32'd100, 16'h1234, 8'h05, 16'h0002, 8'h01));
        send_cmd(make_item(CMD_ADD, 32'hFFFF_FFFF, 16'h0007, 8'h07, 16'h0007, 8'h00));
        send_cmd(make_item(CMD_ADD, 32'd2000, 16'h0008, 8'h08, 16'h8000, 8'h02));
        send_cmd(make_item(CMD_ADD, 32'd2000, 16'h0009, 8'h80, 16'h00FF, 8'h02));
        send_cmd(make_item(CMD_ADD, 32'd2000, 16'h5A5A, 8'hA5, 16'hA5A5, 8'h02));
        send_cmd(make_item(CMD_ADD, 32'd2500, 16'hDEAD, 8'h01, 16'hBEEF, 8'h09));
    endtask

    // Duplicate ack frees only the lower slot; wrong node misses; refill.
    task automatic test_ack_match;
        send_cmd(make_item(CMD_ACK, 32'd300, 16'h1234, 8'h05, 16'h0000, 8'h00));
        send_cmd(make_item(CMD_ACK, 32'd300, 16'h1234, 8'h06, 16'h0000, 8'h00));
        send_cmd(make_item(CMD_ADD, 32'd500, 16'hAAAA, 8'h55, 16'h5555, 8'h03));
    endtask

    // Scans across the 2^32 wrap: zero-retry slots freed, first live one resent.
    task automatic test_check_scan;
        send_cmd(make_item(CMD_CHECK, 32'h0000_0100, 16'h0000, 8'h00, 16'h0000, 8'h00));
        send_cmd(make_item(CMD_CHECK, 32'h0000_0400, 16'h0000, 8'h00, 16'h0000, 8'h00));
        send_cmd(make_item(CMD_CHECK, 32'h0000_2000, 16'h0000, 8'h00, 16'h0000, 8'h00));
    endtask

    task automatic test_clear;
        send_cmd(make_item(CMD_CLEAR, 32'h0000_2000, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF));
        send_cmd(make_item(CMD_CHECK, 32'hFFFF_FFFF, 16'h0000, 8'h00, 16'h0000, 8'h00));
    endtask

    // Zero timeout: everything active counts as timed out at once.
    task automatic test_zero_timeout;
        set_ack_timeout(32'h0000_0000);
        send_cmd(make_item(CMD_ADD, 32'd5, 16'h0101, 8'h01, 16'h1111, 8'h00));
        send_cmd(make_item(CMD_ADD, 32'd5, 16'h0202, 8'h02, 16'h2222, 8'h02));
        send_cmd(make_item(CMD_CHECK, 32'd5, 16'h0000, 8'h00, 16'h0000, 8'h00));
        send_cmd(make_item(CMD_CHECK, 32'd5, 16'h0000, 8'h00, 16'h0000, 8'h00));
    endtask

    // Max timeout: only a full-range elapsed time triggers a resend.
    task automatic test_max_timeout;
        set_ack_timeout(32'hFFFF_FFFF);
        send_cmd(make_item(CMD_ADD, 32'd1, 16'h0303, 8'h03, 16'h3333, 8'h01));
        send_cmd(make_item(CMD_CHECK, 32'd0, 16'h0000, 8'h00, 16'h0000, 8'h00));
        send_cmd(make_item(CMD_CHECK, 32'd0, 16'h0000, 8'h00, 16'h0000, 8'h00));
        send_cmd(make_item(CMD_CHECK, 32'hFFFF_FFFF, 16'h0000, 8'h00, 16'h0000, 8'h00));
    endtask

    // Random traffic across several timeout settings, extremes included.
    task automatic test_random_traffic;
        logic [TIME_W-1:0] timeouts[11];
        timeouts[0]  = 32'd1000;
        timeouts[1]  = 32'd0;
        timeouts[2]  = 32'd1;
        timeouts[3]  = TIME_W'($urandom_range(2, 40));
        timeouts[4]  = 32'd300;
        timeouts[5]  = TIME_W'($urandom_range(1000, 5000));
        timeouts[6]  = 32'hFFFF_FFFF;
        timeouts[7]  = 32'hFFFF_FFFE;
        timeouts[8]  = 32'h8000_0000;
        timeouts[9]  = $urandom();
        timeouts[10] = 32'd1000;
        foreach (timeouts[p])
        begin
            set_ack_timeout(timeouts[p]);
            repeat (100) send_cmd(next_traffic_item());
        end
    endtask

    // ---------------------------------------------------------------------
    // Result side: owns rsp.ready, checks every accepted result beat.
    // Values are read right at the edge, so they are the pre-edge ones.
    // ---------------------------------------------------------------------
    initial
    begin
        int   rx_mode;
        int   rx_left;
        int   stall_cnt;
        logic nxt_ready;
        res_t want;
        rsp.ready = 1'b0;
        rx_mode   = 0;
        rx_left   = 0;
        stall_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected result beat: ok %b msg %h node %h tag %h",
                           rsp.ok, rsp.retry_msg_id, rsp.retry_node_id, rsp.retry_tag);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.ok !== want.ok)
                    begin
                        $error("ok: expected %b, actual %b", want.ok, rsp.ok);
                        fail_count++;
                    end
                    if (rsp.retry_msg_id !== want.retry_msg_id)
                    begin
                        $error("retry_msg_id: expected %h, actual %h",
                               want.retry_msg_id, rsp.retry_msg_id);
                        fail_count++;
                    end
                    if (rsp.retry_node_id !== want.retry_node_id)
                    begin
                        $error("retry_node_id: expected %h, actual %h",
                               want.retry_node_id, rsp.retry_node_id);
                        fail_count++;
                    end
                    if (rsp.retry_tag !== want.retry_tag)
                    begin
                        $error("retry_tag: expected %h, actual %h",
                               want.retry_tag, rsp.retry_tag);
                        fail_count++;
                    end
                end
            end
            // stall pattern: switches between always-ready, coin flip,
            // mostly ready, and random-length stalls broken by single ready cycles
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 150);
            end
            rx_left--;
            case (rx_mode)
                0: nxt_ready = 1'b1;
                1: nxt_ready = 1'($urandom_range(0, 1));
                2: nxt_ready = ($urandom_range(0, 7) != 0);
                default:
                begin
                    if (stall_cnt > 0)
                    begin
                        stall_cnt--;
                        nxt_ready = 1'b0;
                    end
                    else
                    begin
                        nxt_ready = 1'b1;
                        stall_cnt = $urandom_range(0, 16);
                    end
                end
            endcase
            rsp.ready <= nxt_ready;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.cmd         = CMD_ADD;
        req.now_ms      = '0;
        req.msg_id      = '0;
        req.node_id     = '0;
        req.packet_tag  = '0;
        req.max_retries = '0;
        cfg.valid       = 1'b0;
        cfg.ack_timeout = '0;
        fail_count      = 0;
        burst_left      = 1;
        traffic_now     = $urandom();
        cur_timeout     = ACK_TIMEOUT_RST;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_active[i]  = 1'b0;
            tbl_msg[i]     = '0;
            tbl_node[i]    = '0;
            tbl_tag[i]     = '0;
            tbl_sent[i]    = '0;
            tbl_retries[i] = '0;
        end

        // single reset at the start, released on a clock edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_fill_and_full();
        test_ack_match();
        test_check_scan();
        test_clear();
        test_zero_timeout();
        test_max_timeout();
        test_random_traffic();

        // all beats sent; wait out the owed results before the verdict
        drain_table();

        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hang guard: reports TB_ERROR if the run has not finished in time.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
